>>> src/hnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared constants, types and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package hnm_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int RING_SIZE = 2 * MAX_WIDTH;
	localparam int RES_W     = 9;
	localparam int HEIGHT_W  = 20;
	localparam int SCALE_W   = 16;
	localparam int SLOT_W    = $clog2(RING_SIZE);
	localparam int CNT_W     = 17;
	localparam int COORD_W   = 8;
	localparam int STEP_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 1'b1;

	localparam logic [RES_W-1:0]   RES_RESET   = 9'd256;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
	localparam logic [7:0]         ALPHA_FULL  = 8'hFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_STORE,
		ST_MUL,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} ctl_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_READ,
		DP_STORE,
		DP_MUL,
		DP_SHIFT,
		DP_SQ,
		DP_SQRT,
		DP_DIV_LOAD,
		DP_DIV_STEP,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t                       op;
		logic [STEP_W-1:0]            step;
		logic [1:0]                   comp;
		logic [3:0][SLOT_W-1:0]       slot;     // left, right, up, down
		logic [3:0]                   use_win;
		logic [SLOT_W-1:0]            st_slot;
		logic                         st_en;
		logic                         last;
	} dp_cmd_t;

endpackage

>>> src/hnm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnm_ctrl
// Sequencer: frame counters, emit decision, neighbor slots, phase control.
// ----------------------------------------------------------------------------
module hnm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          cfg_we,
	input  logic [hnm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hnm_pkg::CFG_W-1:0]     cfg_wdata,
	output hnm_pkg::dp_cmd_t              cmd
);
	import hnm_pkg::*;

	ctl_state_t state_q, state_n;
	logic [STEP_W-1:0]  step_q;
	logic [1:0]         comp_q;
	logic [RES_W-1:0]   res_q;
	logic [COORD_W-1:0] col_q, ex_q, ey_q;
	logic [RES_W-1:0]   row_q;
	logic [CNT_W-1:0]   recv_q, emit_cnt_q;
	logic               emit_pend_q, store_pend_q, out_valid_q;

	logic [RES_W-1:0] r;
	logic [CNT_W-1:0] total, recv_m1;
	logic             accept, is_sample, emit_s, emit_d, emit, out_free;
	logic [CNT_W-1:0] k_l, k_r, k_u, k_d;
	logic [CNT_W-1:0] r_ext;

	always_comb begin
		if (res_q == '0)
			r = RES_W'(1);
		else if (res_q > RES_W'(MAX_WIDTH))
			r = RES_W'(MAX_WIDTH);
		else
			r = res_q;
	end

	assign r_ext     = CNT_W'(r);
	assign total     = r_ext * r_ext;
	assign recv_m1   = recv_q - CNT_W'(1);
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign is_sample = !op && (row_q < r);
	assign emit_s    = is_sample &&
		((18'(emit_cnt_q) + 18'(r) + 18'd1) <= 18'(recv_q));
	assign emit_d    = !is_sample && (row_q >= r) && (emit_cnt_q < total);
	assign emit      = emit_s || emit_d;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// neighbor sample indices with border clamp
	assign k_l = emit_cnt_q - CNT_W'(ex_q != '0);
	assign k_r = emit_cnt_q + CNT_W'((RES_W'(ex_q) + RES_W'(1)) < r);
	assign k_u = emit_cnt_q - ((ey_q != '0) ? r_ext : '0);
	assign k_d = emit_cnt_q + (((RES_W'(ey_q) + RES_W'(1)) < r) ? r_ext : '0);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && emit)
					state_n = ST_READ;
				else if (accept && is_sample)
					state_n = ST_STORE;
			end
			ST_READ:  if (step_q == STEP_W'(4)) state_n = store_pend_q ? ST_STORE : ST_MUL;
			ST_STORE: state_n = emit_pend_q ? ST_MUL : ST_IDLE;
			ST_MUL:   if (step_q == STEP_W'(1)) state_n = ST_SHIFT;
			ST_SHIFT: state_n = ST_SQ;
			ST_SQ:    if (step_q == STEP_W'(2)) state_n = ST_SQRT;
			ST_SQRT:  if (step_q == STEP_W'(31)) state_n = ST_DIV;
			ST_DIV:   if (step_q == STEP_W'(9) && comp_q == 2'd2) state_n = ST_OUT;
			ST_OUT:   if (out_free) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.step       = step_q;
		cmd.comp       = comp_q;
		cmd.slot[0]    = k_l[SLOT_W-1:0];
		cmd.slot[1]    = k_r[SLOT_W-1:0];
		cmd.slot[2]    = k_u[SLOT_W-1:0];
		cmd.slot[3]    = k_d[SLOT_W-1:0];
		cmd.use_win[0] = (k_l == recv_m1);
		cmd.use_win[1] = (k_r == recv_m1);
		cmd.use_win[2] = (k_u == recv_m1);
		cmd.use_win[3] = (k_d == recv_m1);
		cmd.st_slot    = recv_m1[SLOT_W-1:0];
		cmd.st_en      = (recv_q != '0);
		cmd.last       = (emit_cnt_q == total - CNT_W'(1));
		unique case (state_q)
			ST_IDLE:  cmd.op = accept ? DP_LOAD : DP_NOP;
			ST_READ:  cmd.op = DP_READ;
			ST_STORE: cmd.op = DP_STORE;
			ST_MUL:   cmd.op = DP_MUL;
			ST_SHIFT: cmd.op = DP_SHIFT;
			ST_SQ:    cmd.op = DP_SQ;
			ST_SQRT:  cmd.op = DP_SQRT;
			ST_DIV:   cmd.op = (step_q == '0) ? DP_DIV_LOAD : DP_DIV_STEP;
			ST_OUT:   cmd.op = out_free ? DP_OUT : DP_NOP;
			default:  cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			comp_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_n != state_q) begin
				step_q <= '0;
				comp_q <= '0;
			end else if (state_q == ST_DIV && step_q == STEP_W'(9)) begin
				step_q <= '0;
				comp_q <= comp_q + 2'd1;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q        <= RES_RESET;
			col_q        <= '0;
			row_q        <= '0;
			recv_q       <= '0;
			emit_cnt_q   <= '0;
			ex_q         <= '0;
			ey_q         <= '0;
			emit_pend_q  <= 1'b0;
			store_pend_q <= 1'b0;
		end else if (cfg_we && cfg_index == REG_RESOLUTION) begin
			res_q      <= cfg_wdata[RES_W-1:0];
			col_q      <= '0;
			row_q      <= '0;
			recv_q     <= '0;
			emit_cnt_q <= '0;
			ex_q       <= '0;
			ey_q       <= '0;
		end else if (accept) begin
			emit_pend_q  <= emit;
			store_pend_q <= is_sample;
			if (is_sample) begin
				recv_q <= recv_q + CNT_W'(1);
				if ((RES_W'(col_q) + RES_W'(1)) >= r) begin
					col_q <= '0;
					row_q <= row_q + RES_W'(1);
				end else begin
					col_q <= col_q + COORD_W'(1);
				end
			end
			if (emit_d && (emit_cnt_q + CNT_W'(1)) >= total) begin
				// frame done: back to the start
				col_q      <= '0;
				row_q      <= '0;
				recv_q     <= '0;
				emit_cnt_q <= '0;
				ex_q       <= '0;
				ey_q       <= '0;
			end else if (emit) begin
				emit_cnt_q <= emit_cnt_q + CNT_W'(1);
				if ((RES_W'(ex_q) + RES_W'(1)) >= r) begin
					ex_q <= '0;
					ey_q <= ey_q + COORD_W'(1);
				end else begin
					ex_q <= ex_q + COORD_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

endmodule

>>> src/hnm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnm_datapath
// Sample ring, window register, gradient multiply, iterative square root
// and shared restoring divider for the byte mapping.
// ----------------------------------------------------------------------------
module hnm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hnm_pkg::dp_cmd_t                    cmd,
	input  logic signed [hnm_pkg::HEIGHT_W-1:0] height,
	input  logic                                cfg_we,
	input  logic [hnm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hnm_pkg::CFG_W-1:0]           cfg_wdata,
	output logic [7:0]                          normal_red,
	output logic [7:0]                          normal_green,
	output logic [7:0]                          normal_blue,
	output logic                                frame_last
);
	import hnm_pkg::*;

	logic signed [HEIGHT_W-1:0] mem [RING_SIZE];
	logic signed [HEIGHT_W-1:0] rd_q;
	logic signed [HEIGHT_W-1:0] win_q, h_q;
	logic signed [HEIGHT_W-1:0] samp_q [4];
	logic [3:0][SLOT_W-1:0]     slot_q;
	logic [3:0]                 use_win_q;
	logic [SLOT_W-1:0]          st_slot_q;
	logic                       st_en_q, last_q;
	logic [SCALE_W-1:0]         scale_q;
	logic [36:0]                ax_q, ay_q;
	logic                       negx_q, negy_q;
	logic [29:0]                mx_q, my_q;
	logic [16:0]                mz_q;
	logic [61:0]                acc_q;
	logic [63:0]                v_q, res_q;
	logic [41:0]                rem_q;
	logic [8:0]                 quo_q;
	logic [7:0]                 byte_q [3];

	logic signed [20:0] diff;
	logic signed [37:0] prod;
	logic [6:0]         hi;
	logic [2:0]         sh;
	logic [29:0]        sq_in;
	logic [59:0]        sq;
	logic [63:0]        v_in, r_in, bit_v, trial;
	logic [31:0]        len, mag_c, mag_k;
	logic               neg_c;
	logic [32:0]        num;
	logic [41:0]        nval, dsh;
	logic               ge;
	logic [8:0]         quo_n;
	logic [1:0]         capi;

	assign capi = 2'(cmd.step - STEP_W'(1));

	always_comb begin
		if (cmd.step[0])
			diff = {samp_q[3][HEIGHT_W-1], samp_q[3]} - {samp_q[2][HEIGHT_W-1], samp_q[2]};
		else
			diff = {samp_q[1][HEIGHT_W-1], samp_q[1]} - {samp_q[0][HEIGHT_W-1], samp_q[0]};
		prod = 38'(diff) * 38'($signed({1'b0, scale_q}));
	end

	// scale down until both magnitudes are below 2^30
	always_comb begin
		hi = ax_q[36:30] | ay_q[36:30];
		sh = '0;
		for (int i = 0; i < 7; i++)
			if (hi[i]) sh = 3'(i + 1);
	end

	always_comb begin
		unique case (cmd.step[1:0])
			2'd0:    sq_in = mx_q;
			2'd1:    sq_in = my_q;
			default: sq_in = 30'(mz_q);
		endcase
		sq = 60'(sq_in) * 60'(sq_in);
	end

	always_comb begin
		v_in  = (cmd.step == '0) ? 64'(acc_q) : v_q;
		r_in  = (cmd.step == '0) ? '0 : res_q;
		bit_v = 64'(1) << (6'd62 - {cmd.step, 1'b0});
		trial = r_in + bit_v;
	end

	always_comb begin
		len = (res_q == '0) ? 32'd1 : res_q[31:0];
		unique case (cmd.comp)
			2'd0:    begin mag_c = 32'(mx_q); neg_c = negx_q; end
			2'd1:    begin mag_c = 32'(my_q); neg_c = negy_q; end
			default: begin mag_c = 32'(mz_q); neg_c = 1'b0;   end
		endcase
		mag_k = (mag_c > len) ? len : mag_c;
		num   = neg_c ? ({1'b0, len} - {1'b0, mag_k}) : ({1'b0, len} + {1'b0, mag_k});
		nval  = (42'(num) << 8) - 42'(num) + 42'(len);
		dsh   = 42'({len, 1'b0}) << (4'd9 - cmd.step[3:0]);
		ge    = (rem_q >= dsh);
		quo_n = {quo_q[7:0], ge};
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_STORE && st_en_q)
			mem[st_slot_q] <= win_q;
		if (cmd.op == DP_READ && cmd.step < STEP_W'(4))
			rd_q <= mem[slot_q[cmd.step[1:0]]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			scale_q <= SCALE_RESET;
		end else begin
			if (cfg_we && cfg_index == REG_HEIGHT_SCALE)
				scale_q <= cfg_wdata[SCALE_W-1:0];
			if (cmd.op == DP_STORE)
				win_q <= h_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: begin
				h_q       <= height;
				slot_q    <= cmd.slot;
				use_win_q <= cmd.use_win;
				st_slot_q <= cmd.st_slot;
				st_en_q   <= cmd.st_en;
				last_q    <= cmd.last;
			end
			DP_READ: begin
				// read data is registered, so it lands in the cycle after its address
				if (cmd.step != '0)
					samp_q[capi] <= use_win_q[capi] ? win_q : rd_q;
			end
			DP_MUL: begin
				if (cmd.step[0]) begin
					ay_q   <= prod[37] ? 37'(-prod) : prod[36:0];
					negy_q <= !prod[37] && (prod != '0);
				end else begin
					ax_q   <= prod[37] ? 37'(-prod) : prod[36:0];
					negx_q <= !prod[37] && (prod != '0);
				end
			end
			DP_SHIFT: begin
				mx_q <= 30'(ax_q >> sh);
				my_q <= 30'(ay_q >> sh);
				mz_q <= 17'(17'h10000 >> sh);
			end
			DP_SQ: begin
				acc_q <= (cmd.step == '0) ? 62'(sq) : acc_q + 62'(sq);
			end
			DP_SQRT: begin
				if (v_in >= trial) begin
					v_q   <= v_in - trial;
					res_q <= (r_in >> 1) + bit_v;
				end else begin
					v_q   <= v_in;
					res_q <= r_in >> 1;
				end
			end
			DP_DIV_LOAD: begin
				rem_q <= nval;
				quo_q <= '0;
			end
			DP_DIV_STEP: begin
				if (ge)
					rem_q <= rem_q - dsh;
				quo_q <= quo_n;
				if (cmd.step == STEP_W'(9))
					byte_q[cmd.comp] <= quo_n[8] ? 8'hFF : quo_n[7:0];
			end
			DP_OUT: begin
				normal_red   <= byte_q[0];
				normal_green <= byte_q[1];
				normal_blue  <= byte_q[2];
				frame_last   <= last_q;
			end
			default: ;
		endcase
	end

endmodule

>>> src/heightfield_normal_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_normal_map
// Heightfield to RGBA normal map, central differences with clamped border.
// ----------------------------------------------------------------------------
// Heights arrive in raster order; pixel p is produced when sample
// p + resolution + 1 is transferred, and drain items (op = 1) flush the
// remaining pixels once the frame is complete. A sample that produces no
// pixel only passes through the store state. An item that produces a pixel
// goes through the four ring-memory reads on its single port, the shared
// gradient multiplier, scaling and squares, the two-bit-per-cycle square
// root and the shared divider, once for each of the 3 components. The next
// item is taken while a finished pixel waits on the output register.
// ----------------------------------------------------------------------------
module heightfield_normal_map (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [hnm_pkg::HEIGHT_W-1:0] height,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          normal_red,
	output logic [7:0]                          normal_green,
	output logic [7:0]                          normal_blue,
	output logic [7:0]                          alpha,
	output logic                                frame_last,
	input  logic                                cfg_we,
	input  logic [hnm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hnm_pkg::CFG_W-1:0]           cfg_wdata
);
	import hnm_pkg::*;

	dp_cmd_t cmd;

	assign alpha = ALPHA_FULL;

	hnm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd)
	);

	hnm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.height       (height),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.normal_red   (normal_red),
		.normal_green (normal_green),
		.normal_blue  (normal_blue),
		.frame_last   (frame_last)
	);

endmodule
